FILE: rtl/ookenc_pkg.sv
// Shared constants and types for the OOK remote frame encoder.
`default_nettype none
package ookenc_pkg;

  localparam int unsigned PREAMBLE_TICKS = 32;
  localparam int unsigned FRAME_BITS     = 24;
  localparam int unsigned TICKS_PER_BIT  = 4;

  localparam int unsigned ADDR_W   = 20;
  localparam int unsigned NIBBLE_W = 4;
  localparam int unsigned REP_W    = 4;
  localparam int unsigned CFG_W    = ADDR_W;
  localparam int unsigned PRE_W    = $clog2(PREAMBLE_TICKS);
  localparam int unsigned BITPOS_W = $clog2(FRAME_BITS);
  localparam int unsigned TICK_W   = $clog2(TICKS_PER_BIT);

  localparam logic [PRE_W-1:0]    PRE_LAST  = PRE_W'(PREAMBLE_TICKS - 1);
  localparam logic [BITPOS_W-1:0] BIT_LAST  = BITPOS_W'(FRAME_BITS - 1);
  localparam logic [TICK_W-1:0]   TICK_LAST = TICK_W'(TICKS_PER_BIT - 1);

  // Configuration register indexes
  typedef enum logic [0:0] {
    REG_DEVICE_ADDRESS = 1'b0,
    REG_REPEAT_COUNT   = 1'b1
  } cfg_reg_t;

  // Input item kinds
  typedef enum logic [0:0] {
    ACT_TICK  = 1'b0,
    ACT_START = 1'b1
  } action_t;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'b001,
    PH_PREAMBLE = 3'b010,
    PH_DATA     = 3'b100
  } phase_t;

  typedef struct packed {
    logic pin_level;
    logic busy_res;
    logic frame_end;
  } result_t;

endpackage
`default_nettype wire

FILE: rtl/ook_remote_frame_encoder_top.sv
// Top level of the OOK remote frame encoder: frame sequencer and output buffer.
//
//  channel | signals                         | content
//  --------+---------------------------------+-------------------------------------
//  in      | s_tvalid s_tready s_tdata s_tuser | tdata: data_nibble; tuser: action
//  out     | m_tvalid m_tready m_tdata m_tlast | tdata: pin_level, busy_res; tlast: frame_end
//  cfg     | cfg_we cfg_index cfg_data       | device_address (0), repeat_count (1)
//
// One item per cycle while s_tready is high: the sequencer state updates in the cycle of
// acceptance, and the result is registered in the output register or, under a stall, the skid.
// A two-entry output buffer (result register plus skid) keeps the input open for one
// more item while the output is stalled; s_tready drops only when both are full.
// rst clears the sequencer to idle with the pin high, and repeat_count to 5.
`default_nettype none
module ook_remote_frame_encoder_top
  import ookenc_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  input  wire logic [7:0]       s_tdata,   // [3:0] data_nibble, [7:4] zero
  input  wire logic             s_tuser,   // [0] action
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  output logic [7:0]            m_tdata,   // [0] pin_level, [1] busy_res, [7:2] zero
  output logic                  m_tlast,   // frame_end
  input  wire logic             cfg_we,
  input  wire logic [0:0]       cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data
);

  logic [ADDR_W-1:0]   device_address;
  logic [REP_W-1:0]    repeat_count;

  phase_t              phase, phase_next;
  logic [PRE_W-1:0]    pre_cnt, pre_cnt_next;
  logic [BITPOS_W-1:0] bit_pos, bit_pos_next;
  logic [TICK_W-1:0]   tick, tick_next;
  logic [FRAME_BITS-1:0] frame_word, frame_word_next;
  logic [REP_W-1:0]    repeats_left, repeats_left_next;
  logic                pin, pin_next;
  logic                fend;
  logic                cur_bit;

  result_t             res, out_res, skid_res;
  logic                skid_valid;
  logic                accept;

  assign accept   = s_tvalid && s_tready;
  assign s_tready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      device_address <= '0;
      repeat_count   <= REP_W'(5);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DEVICE_ADDRESS: device_address <= cfg_data[ADDR_W-1:0];
        REG_REPEAT_COUNT:   repeat_count   <= cfg_data[REP_W-1:0];
        default: ;
      endcase
    end
  end

  assign cur_bit = frame_word[BIT_LAST - bit_pos];

  always_comb begin
    phase_next        = phase;
    pre_cnt_next      = pre_cnt;
    bit_pos_next      = bit_pos;
    tick_next         = tick;
    frame_word_next   = frame_word;
    repeats_left_next = repeats_left;
    pin_next          = pin;
    fend              = 1'b0;
    if (s_tuser == ACT_START) begin
      frame_word_next   = {device_address, s_tdata[NIBBLE_W-1:0]};
      pre_cnt_next      = '0;
      bit_pos_next      = '0;
      tick_next         = '0;
      repeats_left_next = repeat_count;
      phase_next        = PH_PREAMBLE;
    end else begin
      unique case (phase)
        PH_PREAMBLE: begin
          pin_next = (pre_cnt == '0);
          if (pre_cnt == PRE_LAST) begin
            pre_cnt_next = '0;
            phase_next   = PH_DATA;
          end else begin
            pre_cnt_next = pre_cnt + 1'b1;
          end
        end
        PH_DATA: begin
          pin_next = cur_bit ? (tick != TICK_LAST) : (tick == '0);
          tick_next = tick + 1'b1;
          if (tick == TICK_LAST) begin
            if (bit_pos == BIT_LAST) begin
              // end of frame: repeat or go idle
              fend         = 1'b1;
              bit_pos_next = '0;
              pre_cnt_next = '0;
              if (repeats_left != '0) begin
                repeats_left_next = repeats_left - 1'b1;
                phase_next        = PH_PREAMBLE;
              end else begin
                phase_next = PH_IDLE;
              end
            end else begin
              bit_pos_next = bit_pos + 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
    res.pin_level = pin_next;
    res.busy_res  = (phase_next != PH_IDLE);
    res.frame_end = fend;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      pre_cnt      <= '0;
      bit_pos      <= '0;
      tick         <= '0;
      repeats_left <= '0;
      pin          <= 1'b1;
    end else if (accept) begin
      phase        <= phase_next;
      pre_cnt      <= pre_cnt_next;
      bit_pos      <= bit_pos_next;
      tick         <= tick_next;
      repeats_left <= repeats_left_next;
      pin          <= pin_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_word <= '0;
    end else if (accept) begin
      frame_word <= frame_word_next;
    end
  end

  // Output register with a skid stage behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (m_tready || !m_tvalid) begin
      if (skid_valid) begin
        m_tvalid   <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        m_tvalid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (m_tready || !m_tvalid) begin
      out_res <= skid_valid ? skid_res : res;
    end else if (accept) begin
      skid_res <= res;
    end
  end

  assign m_tdata = {6'b0, out_res.busy_res, out_res.pin_level};
  assign m_tlast = out_res.frame_end;

  // The skid stage fills only behind a stalled result
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> m_tvalid)
    else $error("skid entry without a result ahead of it");

  a_preamble_counters: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_PREAMBLE) |-> (bit_pos == '0 && tick == '0))
    else $error("bit counters not clear in preamble");

  a_data_precnt: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DATA || phase == PH_IDLE) |-> (pre_cnt == '0))
    else $error("preamble counter not clear outside preamble");

  a_start_restarts: assert property (@(posedge clk) disable iff (rst)
    (accept && s_tuser == ACT_START) |=> (phase == PH_PREAMBLE && pre_cnt == '0))
    else $error("start did not restart the frame");

  a_fend_busy: assert property (@(posedge clk) disable iff (rst)
    (accept && fend) |=> ($past(repeats_left) != '0) == (phase == PH_PREAMBLE))
    else $error("frame end did not repeat or idle as expected");

endmodule
`default_nettype wire
